// ----- hdl/qvr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, pipeline depths and types of the quaternion vector rotation.
// ----------------------------------------------------------------------------
package qvr_pkg;

   // port and product widths
   localparam int IN_W      = 16;
   localparam int PROD_W    = 32;
   localparam int WIDE_W    = 34;

   // block scaling: largest magnitude lands in [2^29, 2^30)
   localparam int MAG_W     = 30;
   localparam int SCALE_MSB = MAG_W - 1;
   localparam int POS_W     = 6;

   // square root of the sum of squares
   localparam int SQUARE_W  = 2 * MAG_W;
   localparam int SUMSQ_W   = SQUARE_W + 2;
   localparam int TEST_W    = SUMSQ_W + 1;
   localparam int SQ_BITS   = SUMSQ_W / 2;
   localparam int NRM_W     = SQ_BITS + 1;

   // rounded division to Q1.14
   localparam int FRAC_BITS = 14;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int DIV_W     = MAG_W + FRAC_BITS + 2;

   // latencies in clock cycles
   localparam int PRE_STAGES = 6;
   localparam int NRM_LAT    = PRE_STAGES + SQ_BITS + 2 + QUO_W + 1;
   localparam int PROD_LAT   = 2;
   localparam int TOP_LAT    = 2 * PROD_LAT + 2 * NRM_LAT;

   typedef logic signed [IN_W-1:0]   q14_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct packed {
      q14_type w;
      q14_type x;
      q14_type y;
      q14_type z;
   } quat_type;

   // what travels alongside the root and division stages
   typedef struct packed {
      logic [3:0][MAG_W-1:0] mag;
      logic [3:0]            neg;
      logic                  zero;
      quat_type              side;
   } carry_type;

endpackage

// ----- hdl/qvr_normalize.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_normalize
// Pipelined unit-length normalization of a four-component fixed-point
// quaternion to Q1.14: block scaling, sum of squares, bit-serial square root
// one bit per stage, rounded division one quotient bit per stage.
// ----------------------------------------------------------------------------
module qvr_normalize (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  qvr_pkg::wide_type comp_in [4],
   input  logic              zero_in,
   input  qvr_pkg::quat_type side_in,
   output logic              out_valid,
   output qvr_pkg::q14_type  unit_out [4],
   output logic              zero_out,
   output qvr_pkg::quat_type side_out
);
   import qvr_pkg::*;

   // stage a: magnitudes and signs
   logic              a_valid_ff;
   logic [WIDE_W-1:0] a_mag_ff [4];
   logic [3:0]        a_neg_ff;
   logic              a_zero_ff;
   quat_type          a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         a_neg_ff[i] <= comp_in[i][WIDE_W-1];
         a_mag_ff[i] <= comp_in[i][WIDE_W-1] ? WIDE_W'(-comp_in[i]) : WIDE_W'(comp_in[i]);
      end
      a_zero_ff <= zero_in;
      a_side_ff <= side_in;
   end

   // stage b: largest magnitude
   logic              b_valid_ff;
   logic [WIDE_W-1:0] b_mag_ff [4];
   logic [WIDE_W-1:0] b_max_ff;
   logic [WIDE_W-1:0] b_max_in;
   logic [WIDE_W-1:0] b_m01;
   logic [WIDE_W-1:0] b_m23;
   logic [3:0]        b_neg_ff;
   logic              b_zero_ff;
   quat_type          b_side_ff;

   always_comb begin
      b_m01    = (a_mag_ff[0] > a_mag_ff[1]) ? a_mag_ff[0] : a_mag_ff[1];
      b_m23    = (a_mag_ff[2] > a_mag_ff[3]) ? a_mag_ff[2] : a_mag_ff[3];
      b_max_in = (b_m01 > b_m23) ? b_m01 : b_m23;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_mag_ff  <= a_mag_ff;
      b_max_ff  <= b_max_in;
      b_neg_ff  <= a_neg_ff;
      b_zero_ff <= a_zero_ff | (b_max_in == '0);
      b_side_ff <= a_side_ff;
   end

   // stage c: leading one position of the largest magnitude
   logic              c_valid_ff;
   logic [WIDE_W-1:0] c_mag_ff [4];
   logic [POS_W-1:0]  c_pos_ff;
   logic [POS_W-1:0]  c_pos_in;
   logic [3:0]        c_neg_ff;
   logic              c_zero_ff;
   quat_type          c_side_ff;

   always_comb begin
      c_pos_in = '0;
      for (int b = 0; b < WIDE_W; b++) begin
         if (b_max_ff[b]) begin
            c_pos_in = POS_W'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_mag_ff  <= b_mag_ff;
      c_pos_ff  <= c_pos_in;
      c_neg_ff  <= b_neg_ff;
      c_zero_ff <= b_zero_ff;
      c_side_ff <= b_side_ff;
   end

   // stage d: block scaling, exact left shift or truncating right shift
   logic                   d_valid_ff;
   logic [MAG_W-1:0]       d_mag_ff [4];
   logic [MAG_W-1:0]       d_mag_in [4];
   logic [WIDE_W+MAG_W-1:0] d_wide;
   logic                   d_right;
   logic [POS_W-1:0]       d_amt;
   logic [3:0]             d_neg_ff;
   logic                   d_zero_ff;
   quat_type               d_side_ff;

   always_comb begin
      d_right = c_pos_ff >= POS_W'(SCALE_MSB);
      d_amt   = d_right ? c_pos_ff - POS_W'(SCALE_MSB) : POS_W'(SCALE_MSB) - c_pos_ff;
      for (int i = 0; i < 4; i++) begin
         d_wide      = (WIDE_W + MAG_W)'(c_mag_ff[i]);
         d_wide      = d_right ? d_wide >> d_amt : d_wide << d_amt;
         d_mag_in[i] = d_wide[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_mag_ff  <= d_mag_in;
      d_neg_ff  <= c_neg_ff;
      d_zero_ff <= c_zero_ff;
      d_side_ff <= c_side_ff;
   end

   // stage e: squares
   logic                e_valid_ff;
   logic [SQUARE_W-1:0] e_sq_ff [4];
   carry_type           e_carry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         e_sq_ff[i]        <= SQUARE_W'(d_mag_ff[i]) * SQUARE_W'(d_mag_ff[i]);
         e_carry_ff.mag[i] <= d_mag_ff[i];
      end
      e_carry_ff.neg  <= d_neg_ff;
      e_carry_ff.zero <= d_zero_ff;
      e_carry_ff.side <= d_side_ff;
   end

   // stage f: sum of squares, loads the root pipeline
   logic               sq_valid_ff [SQ_BITS+1];
   logic [SQ_BITS-1:0] sq_root_ff  [SQ_BITS+1];
   logic [SUMSQ_W-1:0] sq_rem_ff   [SQ_BITS+1];
   carry_type          sq_carry_ff [SQ_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else begin
         sq_valid_ff[0] <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_root_ff[0]  <= '0;
      sq_rem_ff[0]   <= SUMSQ_W'(e_sq_ff[0]) + SUMSQ_W'(e_sq_ff[1])
                      + SUMSQ_W'(e_sq_ff[2]) + SUMSQ_W'(e_sq_ff[3]);
      sq_carry_ff[0] <= e_carry_ff;
   end

   // root stages: one result bit each, remainder kept as sum minus root squared
   for (genvar j = 0; j < SQ_BITS; j++) begin : g_root
      localparam int BI = SQ_BITS - 1 - j;
      logic [TEST_W-1:0] test;
      logic              take;

      always_comb begin
         test = (TEST_W'(sq_root_ff[j]) << (BI + 1)) + (TEST_W'(1) << (2 * BI));
         take = TEST_W'(sq_rem_ff[j]) >= test;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j+1] <= 1'b0;
         end else begin
            sq_valid_ff[j+1] <= sq_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         sq_root_ff[j+1]  <= take ? (sq_root_ff[j] | (SQ_BITS'(1) << BI)) : sq_root_ff[j];
         sq_rem_ff[j+1]   <= take ? (sq_rem_ff[j] - test[SUMSQ_W-1:0]) : sq_rem_ff[j];
         sq_carry_ff[j+1] <= sq_carry_ff[j];
      end
   end

   // round stage: nearest root, ties up
   logic             rd_valid_ff;
   logic [NRM_W-1:0] rd_n_ff;
   carry_type        rd_carry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= sq_valid_ff[SQ_BITS];
      end
   end

   always_ff @(posedge clock) begin
      rd_n_ff     <= NRM_W'(sq_root_ff[SQ_BITS])
                   + NRM_W'(sq_rem_ff[SQ_BITS] > SUMSQ_W'(sq_root_ff[SQ_BITS]));
      rd_carry_ff <= sq_carry_ff[SQ_BITS];
   end

   // prep stage: dividend is magnitude in Q.14 plus half the norm
   logic             dv_valid_ff [QUO_W+1];
   logic [NRM_W-1:0] dv_n_ff     [QUO_W+1];
   logic [DIV_W-1:0] dv_rem_ff   [QUO_W+1][4];
   logic [QUO_W-1:0] dv_quo_ff   [QUO_W+1][4];
   carry_type        dv_carry_ff [QUO_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         dv_rem_ff[0][i] <= (DIV_W'(rd_carry_ff.mag[i]) << FRAC_BITS)
                          + DIV_W'(rd_n_ff >> 1);
         dv_quo_ff[0][i] <= '0;
      end
      dv_n_ff[0]     <= rd_n_ff;
      dv_carry_ff[0] <= rd_carry_ff;
   end

   // division stages: one quotient bit per stage, four lanes
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int BK = QUO_W - 1 - j;
      logic [DIV_W-1:0] sub;
      logic [3:0]       take;

      always_comb begin
         sub = DIV_W'(dv_n_ff[j]) << BK;
         for (int i = 0; i < 4; i++) begin
            take[i] = dv_rem_ff[j][i] >= sub;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         for (int i = 0; i < 4; i++) begin
            dv_rem_ff[j+1][i] <= take[i] ? dv_rem_ff[j][i] - sub : dv_rem_ff[j][i];
            dv_quo_ff[j+1][i] <= take[i] ? (dv_quo_ff[j][i] | (QUO_W'(1) << BK))
                                         : dv_quo_ff[j][i];
         end
         dv_n_ff[j+1]     <= dv_n_ff[j];
         dv_carry_ff[j+1] <= dv_carry_ff[j];
      end
   end

   // output stage: sign restore, zero quaternion forces zero
   logic     o_valid_ff;
   q14_type  o_unit_ff [4];
   logic     o_zero_ff;
   quat_type o_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= dv_valid_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (dv_carry_ff[QUO_W].zero) begin
            o_unit_ff[i] <= '0;
         end else if (dv_carry_ff[QUO_W].neg[i]) begin
            o_unit_ff[i] <= -IN_W'(dv_quo_ff[QUO_W][i]);
         end else begin
            o_unit_ff[i] <= IN_W'(dv_quo_ff[QUO_W][i]);
         end
      end
      o_zero_ff <= dv_carry_ff[QUO_W].zero;
      o_side_ff <= dv_carry_ff[QUO_W].side;
   end

   assign out_valid = o_valid_ff;
   assign unit_out  = o_unit_ff;
   assign zero_out  = o_zero_ff;
   assign side_out  = o_side_ff;

endmodule

// ----- hdl/quaternion_vector_rotation_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_top
// Rotates a vector by a quaternion as q^-1 * (0, v) * q in fixed point and
// returns the unit direction in Q1.14, normalizing after each product.
//
//   channel   handshake            payload
//   request   start / busy         req_vec_x/y/z, req_quat_w/x/y/z
//   response  rsp_valid (strobe)   rsp_out_x/y/z, rsp_zero_norm
//
// One transaction enters per clock while busy is low; each passes through
// 2 product stages and 55 normalize stages, twice, before it returns.
// Latency is set by the bit-serial square root (31 stages) and divider
// (15 stages) inside each normalize unit.
// busy is high only during reset; synchronous reset empties the pipeline.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qvr_pkg::q14_type req_vec_x,
   input  qvr_pkg::q14_type req_vec_y,
   input  qvr_pkg::q14_type req_vec_z,
   input  qvr_pkg::q14_type req_quat_w,
   input  qvr_pkg::q14_type req_quat_x,
   input  qvr_pkg::q14_type req_quat_y,
   input  qvr_pkg::q14_type req_quat_z,
   output logic             rsp_valid,
   output qvr_pkg::q14_type rsp_out_x,
   output qvr_pkg::q14_type rsp_out_y,
   output qvr_pkg::q14_type rsp_out_z,
   output logic             rsp_zero_norm
);
   import qvr_pkg::*;

   logic accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   // first product, stage 1: partial products of conj(q) * (0, v)
   logic     p1_valid_ff;
   prod_type p1_ff [12];
   quat_type p1_quat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff[0]  <= req_vec_x * req_quat_x;
      p1_ff[1]  <= req_vec_y * req_quat_y;
      p1_ff[2]  <= req_vec_z * req_quat_z;
      p1_ff[3]  <= req_vec_x * req_quat_w;
      p1_ff[4]  <= req_vec_y * req_quat_z;
      p1_ff[5]  <= req_vec_z * req_quat_y;
      p1_ff[6]  <= req_vec_x * req_quat_z;
      p1_ff[7]  <= req_vec_y * req_quat_w;
      p1_ff[8]  <= req_vec_z * req_quat_x;
      p1_ff[9]  <= req_vec_x * req_quat_y;
      p1_ff[10] <= req_vec_y * req_quat_x;
      p1_ff[11] <= req_vec_z * req_quat_w;
      p1_quat_ff <= '{w: req_quat_w, x: req_quat_x, y: req_quat_y, z: req_quat_z};
   end

   // first product, stage 2: exact sums
   logic     s1_valid_ff;
   wide_type s1_comp_ff [4];
   quat_type s1_quat_ff;
   wide_type e1 [12];

   always_comb begin
      for (int k = 0; k < 12; k++) begin
         e1[k] = WIDE_W'(p1_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_comp_ff[0] <= e1[0] + e1[1] + e1[2];
      s1_comp_ff[1] <= e1[3] + e1[4] - e1[5];
      s1_comp_ff[2] <= e1[7] + e1[8] - e1[6];
      s1_comp_ff[3] <= e1[9] - e1[10] + e1[11];
      s1_quat_ff    <= p1_quat_ff;
   end

   // first normalization
   logic     n1_valid;
   q14_type  n1_unit [4];
   logic     n1_zero;
   quat_type n1_quat;

   qvr_normalize u_norm_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .comp_in   (s1_comp_ff),
      .zero_in   (1'b0),
      .side_in   (s1_quat_ff),
      .out_valid (n1_valid),
      .unit_out  (n1_unit),
      .zero_out  (n1_zero),
      .side_out  (n1_quat)
   );

   // second product, stage 1: partial products of u * q
   q14_type  qv [4];
   logic     p2_valid_ff;
   prod_type p2_ff [16];
   logic     p2_zero_ff;

   assign qv[0] = n1_quat.w;
   assign qv[1] = n1_quat.x;
   assign qv[2] = n1_quat.y;
   assign qv[3] = n1_quat.z;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= n1_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 4; b++) begin
            p2_ff[4*a+b] <= qv[a] * n1_unit[b];
         end
      end
      p2_zero_ff <= n1_zero;
   end

   // second product, stage 2: exact sums
   logic     s2_valid_ff;
   wide_type s2_comp_ff [4];
   logic     s2_zero_ff;
   wide_type e2 [16];

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         e2[k] = WIDE_W'(p2_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_comp_ff[0] <= e2[0] - e2[5] - e2[10] - e2[15];
      s2_comp_ff[1] <= e2[1] + e2[4] - e2[11] + e2[14];
      s2_comp_ff[2] <= e2[2] + e2[7] + e2[8] - e2[13];
      s2_comp_ff[3] <= e2[3] - e2[6] + e2[9] + e2[12];
      s2_zero_ff    <= p2_zero_ff;
   end

   // second normalization, drives the response directly
   q14_type n2_unit [4];

   qvr_normalize u_norm_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .comp_in   (s2_comp_ff),
      .zero_in   (s2_zero_ff),
      .side_in   ('0),
      .out_valid (rsp_valid),
      .unit_out  (n2_unit),
      .zero_out  (rsp_zero_norm),
      .side_out  ()
   );

   assign rsp_out_x = n2_unit[1];
   assign rsp_out_y = n2_unit[2];
   assign rsp_out_z = n2_unit[3];

   // checks
   a_zero_forces_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_norm) |-> (rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0))
      else $error("zero norm with nonzero direction");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_x >= -16'sd16384 && rsp_out_x <= 16'sd16384 &&
                     rsp_out_y >= -16'sd16384 && rsp_out_y <= 16'sd16384 &&
                     rsp_out_z >= -16'sd16384 && rsp_out_z <= 16'sd16384))
      else $error("direction component outside unit range");

   a_accept_returns: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##TOP_LAT rsp_valid)
      else $error("accepted transaction did not return");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##TOP_LAT !rsp_valid)
      else $error("response without a transaction");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (accept && req_vec_x == '0 && req_vec_y == '0 && req_vec_z == '0)
         |-> ##TOP_LAT (rsp_valid && rsp_zero_norm))
      else $error("zero vector not flagged");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the quaternion vector rotation block against a bit-exact predictor.
// Directed extremes and zero-norm cases run first, then random vectors and
// quaternions through phases of sender idling; results are compared in order.
// ----------------------------------------------------------------------------
module tb_top;
   import qvr_pkg::*;

   typedef struct {
      q14_type vx, vy, vz, qw, qx, qy, qz;
   } rot_req_type;

   typedef struct {
      q14_type ox, oy, oz;
      logic    zn;
   } rot_rsp_type;

   logic    clock, reset, start, busy;
   q14_type req_vec_x, req_vec_y, req_vec_z;
   q14_type req_quat_w, req_quat_x, req_quat_y, req_quat_z;
   logic    rsp_valid, rsp_zero_norm;
   q14_type rsp_out_x, rsp_out_y, rsp_out_z;

   rot_req_type pending_q[$];
   rot_rsp_type expected_q[$];
   int          idle_pct;
   bit          hold_sender;
   bit          stim_done;
   int          mismatches = 0;
   longint      cycles = 0;

   quaternion_vector_rotation_top dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // rounded integer square root, ties up
   function automatic longint unsigned round_sqrt(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (s > r) r++;
      return r;
   endfunction

   // block scale, sqrt and rounded divide to unit length in q1.14
   function automatic bit unit_quat(input longint p[4], output longint u[4]);
      longint unsigned mag[4], m, s, n, q;
      bit neg[4];
      m = 0;
      s = 0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = p[i] < 0;
         mag[i] = neg[i] ? -p[i] : p[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         for (int i = 0; i < 4; i++) u[i] = 0;
         return 1;
      end
      while (m >= (64'd1 << 30)) begin
         for (int i = 0; i < 4; i++) mag[i] >>= 1;
         m >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         for (int i = 0; i < 4; i++) mag[i] <<= 1;
         m <<= 1;
      end
      for (int i = 0; i < 4; i++) s += mag[i] * mag[i];
      n = round_sqrt(s);
      for (int i = 0; i < 4; i++) begin
         q = (mag[i] * 16384 + n / 2) / n;
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 0;
   endfunction

   // expected rotated unit direction
   function automatic rot_rsp_type rotate_vector(rot_req_type t);
      longint a, b, c, w, x, y, z;
      longint p[4], u[4], v[4], r[4];
      bit zero;
      rot_rsp_type o;
      a = t.vx; b = t.vy; c = t.vz;
      w = t.qw; x = t.qx; y = t.qy; z = t.qz;
      p[0] = a * x + b * y + c * z;
      p[1] = a * w + b * z - c * y;
      p[2] = -a * z + b * w + c * x;
      p[3] = a * y - b * x + c * w;
      zero = unit_quat(p, u);
      v[0] = w * u[0] - x * u[1] - y * u[2] - z * u[3];
      v[1] = w * u[1] + x * u[0] - y * u[3] + z * u[2];
      v[2] = w * u[2] + x * u[3] + y * u[0] - z * u[1];
      v[3] = w * u[3] - x * u[2] + y * u[1] + z * u[0];
      if (!zero) zero = unit_quat(v, r);
      o.ox = zero ? '0 : q14_type'(r[1]);
      o.oy = zero ? '0 : q14_type'(r[2]);
      o.oz = zero ? '0 : q14_type'(r[3]);
      o.zn = zero;
      return o;
   endfunction

   function automatic q14_type rand_field(int mode);
      case (mode)
         0: return q14_type'($urandom);
         1: return q14_type'($urandom_range(0, 4) - 2);
         2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
         default: return q14_type'($urandom_range(0, 32767) - 16384);
      endcase
   endfunction

   function automatic rot_req_type rand_req();
      rot_req_type t;
      int m;
      m = $urandom_range(0, 9);
      // mostly full-range, some small, some extremes, some zero vectors
      t.vx = rand_field(m < 6 ? 0 : m - 6);
      t.vy = rand_field(m < 6 ? 0 : m - 6);
      t.vz = rand_field(m < 6 ? 0 : m - 6);
      t.qw = rand_field($urandom_range(0, 3) == 0 ? 3 : 0);
      t.qx = rand_field($urandom_range(0, 3) == 0 ? 3 : 0);
      t.qy = rand_field($urandom_range(0, 3) == 0 ? 3 : 0);
      t.qz = rand_field($urandom_range(0, 3) == 0 ? 3 : 0);
      if ($urandom_range(0, 39) == 0) {t.vx, t.vy, t.vz} = '0;
      if ($urandom_range(0, 39) == 0) {t.qw, t.qx, t.qy, t.qz} = '0;
      return t;
   endfunction

   function automatic rot_req_type mk(int vx, int vy, int vz, int qw, int qx, int qy,
                                      int qz);
      rot_req_type t;
      t.vx = q14_type'(vx); t.vy = q14_type'(vy); t.vz = q14_type'(vz);
      t.qw = q14_type'(qw); t.qx = q14_type'(qx); t.qy = q14_type'(qy);
      t.qz = q14_type'(qz);
      return t;
   endfunction

   // driver: one transaction per accepted edge
   always @(posedge clock) begin
      rot_req_type t;
      if (reset) begin
         start      <= 1'b0;
         req_vec_x  <= '0; req_vec_y  <= '0; req_vec_z  <= '0;
         req_quat_w <= '0; req_quat_x <= '0; req_quat_y <= '0;
         req_quat_z <= '0;
      end else begin
         if (start && !busy) begin
            t.vx = req_vec_x; t.vy = req_vec_y; t.vz = req_vec_z;
            t.qw = req_quat_w; t.qx = req_quat_x; t.qy = req_quat_y;
            t.qz = req_quat_z;
            expected_q.push_back(rotate_vector(t));
            void'(pending_q.pop_front());
         end
         if (pending_q.size() > 0 && !hold_sender &&
             ($urandom_range(1, 100) > idle_pct)) begin
            t = pending_q[0];
            start      <= 1'b1;
            req_vec_x  <= t.vx; req_vec_y  <= t.vy; req_vec_z  <= t.vz;
            req_quat_w <= t.qw; req_quat_x <= t.qx; req_quat_y <= t.qy;
            req_quat_z <= t.qz;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      rot_rsp_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            e = expected_q.pop_front();
            if (e.ox !== rsp_out_x || e.oy !== rsp_out_y || e.oz !== rsp_out_z ||
                e.zn !== rsp_zero_norm) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d zn=%0b got %0d %0d %0d zn=%0b",
                           e.ox, e.oy, e.oz, e.zn, rsp_out_x, rsp_out_y,
                           rsp_out_z, rsp_zero_norm);
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles > 200000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // stimulus and phases
   initial begin
      int phase_pct[4] = '{0, 81, 0, 26};
      stim_done = 0;
      hold_sender = 0;
      idle_pct = 0;
      reset = 1'b1;
      // directed: identity, extremes, zero vector, zero quaternion
      pending_q.push_back(mk(1, 0, 0, 16384, 0, 0, 0));
      pending_q.push_back(mk(0, 1, 0, 11585, 0, 0, 11585));
      pending_q.push_back(mk(0, 0, 1, 0, 16384, 0, 0));
      pending_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
      pending_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
      pending_q.push_back(mk(-32768, 32767, 0, 32767, -32768, 0, 1));
      pending_q.push_back(mk(0, 0, 0, 16384, 0, 0, 0));
      pending_q.push_back(mk(5, -7, 3, 0, 0, 0, 0));
      pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));
      pending_q.push_back(mk(1, 1, 1, 1, 0, 0, 0));
      pending_q.push_back(mk(-1, 0, 0, 0, 0, 0, -1));
      pending_q.push_back(mk(32767, -1, 1, -1, 1, -32768, 0));
      pending_q.push_back(mk(1, 0, 0, 0, 1, 0, 0));
      pending_q.push_back(mk(-32768, 0, 0, -16384, 0, 16384, 0));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_pct[p];
         for (int i = 0; i < 110; i++) pending_q.push_back(rand_req());
         while (pending_q.size() > 0) @(posedge clock);
         // pause the sender until everything in flight has drained
         if (p == 1) begin
            hold_sender = 1;
            while (expected_q.size() > 0) @(posedge clock);
            hold_sender = 0;
         end
      end
      @(posedge clock);
      while (expected_q.size() > 0) @(posedge clock);
      repeat (TOP_LAT + 20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
